FILE: rtl/quaternion_to_euler_angles_unit_assert.svh
// Assertion macros for the quaternion to Euler angle unit.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define QTE_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define QTE_ASSERT_SAME(lbl, clk, rst_n, ant, cons, msg)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg)
`endif
`endif

FILE: rtl/qte_pkg.sv
// Shared types, constants and functions of the quaternion to Euler angle unit.
// No dependencies.
package qte_pkg;

    localparam int QUAT_W  = 16;
    localparam int CIN_W   = 35;   // width of an atan2 operand
    localparam int CW      = 62;   // CORDIC datapath width
    localparam int ZW      = 34;   // CORDIC angle accumulator width
    localparam int MW      = 59;   // magnitude window for normalization
    localparam int SQ_W    = 62;   // square root datapath width
    localparam int ROOT_W  = 31;
    localparam int SQ_STEPS = 31;
    localparam int NORM_STEPS = 6;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

    typedef enum logic [1:0] {
        PC_GENERAL = 2'd0,
        PC_NORTH   = 2'd1,
        PC_SOUTH   = 2'd2
    } t_pole_case;

    typedef struct packed {
        logic signed [31:0]      s;
        logic signed [CIN_W-1:0] ycy;
        logic signed [CIN_W-1:0] ycx;
        logic signed [CIN_W-1:0] zcy;
        logic signed [CIN_W-1:0] zcx;
        t_pole_case              pc;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cord;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sqrt;

    // Arctangent of 2^-i in radians with 30 fraction bits.
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round an angle with 30 fraction bits to nearest (ties up) with 13.
    function automatic logic signed [17:0] round_q13(input logic signed [ZW:0] v);
        logic signed [ZW:0] t;
        t = v + 35'sd65536;
        return 18'(t >>> 17);
    endfunction

endpackage

FILE: rtl/quaternion_to_euler_angles_unit.sv
// Top level of the quaternion to Euler angle unit.
// Depends on qte_pkg, qte_sqrt_cell, qte_cordic and the assertion header.
//
// Usage: a quaternion (x, y, z, w, signed Q1.15) enters on the input channel
// with i_valid; the transfer happens at a clock edge where o_stall is low.
// Each quaternion yields one result on the output channel: angle_x = asin(2t)
// with t = xy + zw, angle_y, angle_z (radians, Q3.13) and the pole case code.
// The unit is a row of pipeline cells: three arithmetic stages, a 31-cell
// square root chain, a 7-cell CORDIC front end and CORDIC_STAGES rotation
// cells, then the output register. Throughput is one quaternion per cycle
// while the row advances: every cell hands its data to the next in each
// cycle unless o_stall is high.
// When the receiver stalls, the output register holds its result; the row
// keeps moving while its last cell is empty and stops, with o_stall high,
// only when the last cell holds a result that cannot move on.
// Synchronous active-low reset empties the pipeline and loads the pole
// tolerance with its default of 1074. The user must write the tolerance register
// via i_cfg_wr_en only while the unit is idle; the unit does not enforce this.
`include "quaternion_to_euler_angles_unit_assert.svh"

module quaternion_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [19:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_angle_x,
    output logic signed [16:0] o_angle_y,
    output logic signed [15:0] o_angle_z,
    output logic [1:0]         o_pole_case
);
    localparam int CLAT = 1 + qte_pkg::NORM_STEPS + CORDIC_STAGES;
    localparam int DLY  = qte_pkg::SQ_STEPS + 1;
    localparam int TOT  = 3 + qte_pkg::SQ_STEPS + CLAT;
    localparam int CW_I = qte_pkg::CIN_W;

    // Control.
    logic             r_vld [0:TOT-1];
    logic             r_out_valid;
    logic [19:0]      r_tol;
    logic             w_adv;
    logic             w_out_rdy;

    // Stage A: products.
    logic signed [31:0] r_xy, r_zw, r_yw, r_xz, r_yy, r_zz, r_xw, r_yz, r_xx;
    logic signed [15:0] r_ax, r_aw;

    // Stage B: t, clamped s, pole decision and atan2 operands.
    logic signed [32:0] w_t;
    logic signed [33:0] w_s2;
    logic signed [33:0] w_dn;
    logic signed [33:0] w_ds;
    logic signed [33:0] w_tol;
    qte_pkg::t_side     n_side;
    qte_pkg::t_side     r_side;

    // Stage C and on.
    logic signed [32:0] w_ca;
    logic signed [32:0] w_cb;
    logic [63:0]        w_prod;
    qte_pkg::t_sqrt     r_sq_in;
    qte_pkg::t_sqrt     w_sq [0:qte_pkg::SQ_STEPS];
    qte_pkg::t_side     r_dly [0:DLY-1];
    qte_pkg::t_side     w_al;
    logic [qte_pkg::ROOT_W-1:0] w_root;
    qte_pkg::t_pole_case r_pc [0:CLAT-1];

    logic signed [qte_pkg::ZW-1:0] w_zx, w_zy, w_zz;
    logic signed [qte_pkg::ZW:0]   w_zy2;
    logic signed [17:0]            w_rx, w_ry, w_rz;

    logic signed [14:0] r_angle_x;
    logic signed [16:0] r_angle_y;
    logic signed [15:0] r_angle_z;
    qte_pkg::t_pole_case r_pole_case;

    // The row advances unless the last cell holds a result that the stalled
    // output register cannot take.
    assign w_out_rdy = !r_out_valid || !i_stall;
    assign w_adv     = w_out_rdy || !r_vld[TOT-1];
    assign o_stall   = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 20'd1074;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld[0] <= i_valid;
                for (int k = 1; k < TOT; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_out_rdy) begin
                r_out_valid <= r_vld[TOT-1];
            end
        end
    end

    // Stage A: nine 16 by 16 products.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xy <= i_quat_x * i_quat_y;
            r_zw <= i_quat_z * i_quat_w;
            r_yw <= i_quat_y * i_quat_w;
            r_xz <= i_quat_x * i_quat_z;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xw <= i_quat_x * i_quat_w;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_ax <= i_quat_x;
            r_aw <= i_quat_w;
        end
    end

    // Stage B. The north band is tested first, so it wins when bands overlap.
    always_comb begin
        w_t   = 33'(r_xy) + 33'(r_zw);
        w_s2  = 34'(w_t) <<< 1;
        w_dn  = 34'(w_t) - 34'sd536870912;
        w_ds  = 34'(w_t) + 34'sd536870912;
        w_tol = 34'(r_tol);
        if (w_s2 > 34'sd1073741824) begin
            n_side.s = 32'sd1073741824;
        end else if (w_s2 < -34'sd1073741824) begin
            n_side.s = -32'sd1073741824;
        end else begin
            n_side.s = 32'(w_s2);
        end
        n_side.ycy = (CW_I'(r_yw) - CW_I'(r_xz)) <<< 1;
        n_side.ycx = 35'sd1073741824 - ((CW_I'(r_yy) + CW_I'(r_zz)) <<< 1);
        n_side.zcy = (CW_I'(r_xw) - CW_I'(r_yz)) <<< 1;
        n_side.zcx = 35'sd1073741824 - ((CW_I'(r_xx) + CW_I'(r_zz)) <<< 1);
        if (w_dn >= -w_tol && w_dn <= w_tol) begin
            n_side.pc  = qte_pkg::PC_NORTH;
            n_side.ycy = CW_I'(r_ax);
            n_side.ycx = CW_I'(r_aw);
        end else if (w_ds >= -w_tol && w_ds <= w_tol) begin
            n_side.pc  = qte_pkg::PC_SOUTH;
            n_side.ycy = CW_I'(r_ax);
            n_side.ycx = CW_I'(r_aw);
        end else begin
            n_side.pc  = qte_pkg::PC_GENERAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side <= n_side;
        end
    end

    // Stage C: (1 - s)(1 + s) with 60 fraction bits, the square root operand.
    assign w_ca   = 33'sd1073741824 - 33'(r_side.s);
    assign w_cb   = 33'sd1073741824 + 33'(r_side.s);
    assign w_prod = 64'(w_ca[31:0]) * 64'(w_cb[31:0]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_in.v   <= w_prod[qte_pkg::SQ_W-1:0];
            r_sq_in.res <= '0;
            r_dly[0]    <= r_side;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // Square root chain, one result bit per cell.
    assign w_sq[0] = r_sq_in;
    for (genvar k = 0; k < qte_pkg::SQ_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell #(.BIT_POS(2 * (qte_pkg::SQ_STEPS - 1 - k))) u_sqrt (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_d   (w_sq[k]),
            .o_d   (w_sq[k+1])
        );
    end

    assign w_root = w_sq[qte_pkg::SQ_STEPS].res[qte_pkg::ROOT_W-1:0];
    assign w_al   = r_dly[DLY-1];

    // Three atan2 units run side by side.
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (CW_I'(w_al.s)),
        .i_x   (CW_I'(w_root)),
        .o_z   (w_zx)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (w_al.ycy),
        .i_x   (w_al.ycx),
        .o_z   (w_zy)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_y   (w_al.zcy),
        .i_x   (w_al.zcx),
        .o_z   (w_zz)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pc[0] <= w_al.pc;
            for (int k = 1; k < CLAT; k++) begin
                r_pc[k] <= r_pc[k-1];
            end
        end
    end

    // At a pole the y angle is twice the atan2 of (x, w), negated in the south.
    always_comb begin
        unique case (r_pc[CLAT-1])
            qte_pkg::PC_NORTH: w_zy2 = (qte_pkg::ZW + 1)'(w_zy) <<< 1;
            qte_pkg::PC_SOUTH: w_zy2 = -((qte_pkg::ZW + 1)'(w_zy) <<< 1);
            default:           w_zy2 = (qte_pkg::ZW + 1)'(w_zy);
        endcase
        w_rx = qte_pkg::round_q13((qte_pkg::ZW + 1)'(w_zx));
        w_ry = qte_pkg::round_q13(w_zy2);
        w_rz = qte_pkg::round_q13((qte_pkg::ZW + 1)'(w_zz));
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_angle_x   <= w_rx[14:0];
            r_angle_y   <= w_ry[16:0];
            r_angle_z   <= (r_pc[CLAT-1] == qte_pkg::PC_GENERAL) ? w_rz[15:0] : '0;
            r_pole_case <= r_pc[CLAT-1];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_angle_x   = r_angle_x;
    assign o_angle_y   = r_angle_y;
    assign o_angle_z   = r_angle_z;
    assign o_pole_case = r_pole_case;

    `QTE_ASSERT_SAME(a_pole_zero_z, i_clk, i_rst_n,
        o_valid && (o_pole_case != qte_pkg::PC_GENERAL), o_angle_z == '0,
        "pole result carries a nonzero z angle")
    `QTE_ASSERT_SAME(a_empty_out_no_stall, i_clk, i_rst_n,
        !r_out_valid, !o_stall, "input stalled while the output register is empty")
    `QTE_ASSERT_NEXT(a_last_moves_out, i_clk, i_rst_n,
        r_vld[TOT-1] && w_out_rdy, o_valid, "finished item did not reach the output")
endmodule

FILE: rtl/qte_sqrt_cell.sv
// One registered step of the integer square root chain.
// Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_sqrt i_d,
    output qte_pkg::t_sqrt o_d
);
    localparam logic [qte_pkg::SQ_W-1:0] BIT_VAL = qte_pkg::SQ_W'(1) << BIT_POS;

    qte_pkg::t_sqrt n_d;
    qte_pkg::t_sqrt r_d;
    logic [qte_pkg::SQ_W-1:0] w_trial;

    always_comb begin
        w_trial = i_d.res + BIT_VAL;
        if (i_d.v >= w_trial) begin
            n_d.v   = i_d.v - w_trial;
            n_d.res = (i_d.res >> 1) + BIT_VAL;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/qte_norm_cell.sv
// One registered step of the CORDIC operand normalizer (left shift by SHIFT
// when the magnitude is small enough). Depends on qte_pkg.
module qte_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  qte_pkg::t_cord          i_d,
    input  logic [qte_pkg::MW-1:0]  i_m,
    output qte_pkg::t_cord          o_d,
    output logic [qte_pkg::MW-1:0]  o_m
);
    qte_pkg::t_cord         n_d;
    logic [qte_pkg::MW-1:0] n_m;
    qte_pkg::t_cord         r_d;
    logic [qte_pkg::MW-1:0] r_m;
    logic                   w_small;

    assign w_small = (i_m[qte_pkg::MW-1 -: SHIFT] == '0);

    always_comb begin
        n_d = i_d;
        n_m = i_m;
        if (w_small) begin
            n_d.x = i_d.x <<< SHIFT;
            n_d.y = i_d.y <<< SHIFT;
            n_m   = i_m << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
            r_m <= n_m;
        end
    end

    assign o_d = r_d;
    assign o_m = r_m;
endmodule

FILE: rtl/qte_rot_cell.sv
// One registered CORDIC vectoring micro-rotation by atan(2^-IDX).
// Depends on qte_pkg.
module qte_rot_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_cord i_d,
    output qte_pkg::t_cord o_d
);
    localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::atan_q30(IDX);

    qte_pkg::t_cord n_d;
    qte_pkg::t_cord r_d;
    logic signed [qte_pkg::CW-1:0] w_xs;
    logic signed [qte_pkg::CW-1:0] w_ys;

    assign w_xs = i_d.x >>> IDX;
    assign w_ys = i_d.y >>> IDX;

    always_comb begin
        n_d = i_d;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ANG;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: rtl/qte_cordic.sv
// Pipelined atan2: half-plane fold, six normalizer cells, then a row of
// rotation cells. Depends on qte_pkg, qte_norm_cell and qte_rot_cell.
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [qte_pkg::CIN_W-1:0]    i_y,
    input  logic signed [qte_pkg::CIN_W-1:0]    i_x,
    output logic signed [qte_pkg::ZW-1:0]       o_z
);
    localparam int NS = qte_pkg::NORM_STEPS;

    qte_pkg::t_cord         n_pre;
    logic [qte_pkg::MW-1:0] n_m;
    qte_pkg::t_cord         w_nd [0:NS];
    logic [qte_pkg::MW-1:0] w_nm [0:NS];
    qte_pkg::t_cord         w_rd [0:STAGES];
    logic signed [qte_pkg::CW-1:0] w_x;
    logic signed [qte_pkg::CW-1:0] w_y;
    logic signed [qte_pkg::CW-1:0] w_ay;
    qte_pkg::t_cord         r_pre;
    logic [qte_pkg::MW-1:0] r_m;

    // Fold the left half-plane onto the right one and find the magnitude.
    always_comb begin
        w_x = qte_pkg::CW'(i_x);
        w_y = qte_pkg::CW'(i_y);
        n_pre.zero = (i_x == '0) && (i_y == '0);
        if (w_x < 0) begin
            n_pre.x = -w_x;
            n_pre.y = -w_y;
            n_pre.z = (w_y >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
        end else begin
            n_pre.x = w_x;
            n_pre.y = w_y;
            n_pre.z = '0;
        end
        w_ay = (n_pre.y < 0) ? -n_pre.y : n_pre.y;
        n_m  = (n_pre.x > w_ay) ? qte_pkg::MW'(n_pre.x) : qte_pkg::MW'(w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
            r_m   <= n_m;
        end
    end

    assign w_nd[0] = r_pre;
    assign w_nm[0] = r_m;

    // Shifts of 32, 16, 8, 4, 2 and 1 bring the magnitude into [2^58, 2^59).
    for (genvar k = 0; k < NS; k++) begin : g_norm
        qte_norm_cell #(.SHIFT(1 << (NS - 1 - k))) u_norm (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_nd[k]),
            .i_m   (w_nm[k]),
            .o_d   (w_nd[k+1]),
            .o_m   (w_nm[k+1])
        );
    end

    assign w_rd[0] = w_nd[NS];

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        qte_rot_cell #(.IDX(i)) u_rot (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (w_rd[i]),
            .o_d   (w_rd[i+1])
        );
    end

    assign o_z = w_rd[STAGES].zero ? '0 : w_rd[STAGES].z;
endmodule
